>>> hw/rtl/fsr_pkg.sv
// shared constants, codes and types for the framed serial receiver
// no dependencies; imported by fsr_ram users and the top level
`default_nettype none

package fsr_pkg;

	// decoded bytes per bank of the double-buffered store
	localparam int BANK_DEPTH = 256;
	localparam int STORE_DEPTH = 2 * BANK_DEPTH;
	localparam int ADDR_W = $clog2(STORE_DEPTH);
	// decoded count holds 0 .. BANK_DEPTH
	localparam int CNT_W = $clog2(BANK_DEPTH + 1);
	localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

	localparam logic [7:0] START_CODE = 8'hFF;

	// request codes
	localparam logic [1:0] REQ_RX_BYTE = 2'd0;
	localparam logic [1:0] REQ_READ_BYTE = 2'd1;
	localparam logic [1:0] REQ_INFO = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_OWN_ADDRESS = 2'd0;
	localparam logic [1:0] CFG_MASTER_ADDRESS = 2'd1;
	localparam logic [1:0] CFG_DEVICE_IS_MASTER = 2'd2;

	typedef enum logic [2:0] {
		PH_WAIT  = 3'd0,
		PH_ADDR  = 3'd1,
		PH_LEN   = 3'd2,
		PH_DATA  = 3'd3,
		PH_CHECK = 3'd4
	} phase_t;

	// result of one transaction, read data still to come from the store
	typedef struct packed {
		logic       frame_done;
		logic       frame_ok;
		logic       ack_request;
		logic       rd_hit;
		logic [7:0] msg_address;
		logic [7:0] msg_length;
		logic       msg_valid;
	} result_t;

endpackage

`default_nettype wire

>>> hw/rtl/fsr_ram.sv
// generic single-clock ram, one write port and one registered read port
// no dependencies
`default_nettype none

module fsr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512,
	parameter int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/framed_serial_receiver.sv
// two register stages, stage 1 and the output register; the result passes through both to reach the outputs
// throughput: one transaction per cycle while out_ready is high; set by the single store access per byte
// a stalled output holds one result and one more in flight before in_ready drops
// reset clears the parser, the committed frame info and the configuration
// the message store is not cleared; only bytes of a committed frame are readable
`default_nettype none

module framed_serial_receiver
	import fsr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] req_type,
	input  wire logic [7:0] rx_byte,
	input  wire logic [7:0] read_index,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            frame_done,
	output logic            frame_ok,
	output logic            ack_request,
	output logic      [7:0] read_data,
	output logic      [7:0] msg_address,
	output logic      [7:0] msg_length,
	output logic            msg_valid,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data
);

	// configuration
	logic [7:0] own_q;
	logic       master_mode_q;

	// parser state
	phase_t           phase_q, phase_nxt;
	logic [7:0]       faddr_q, faddr_nxt;
	logic [7:0]       rawlen_q, rawlen_nxt;
	logic [7:0]       rawcnt_q, rawcnt_nxt;
	logic [6:0]       sum_q, sum_nxt;
	logic [6:0]       high_q, high_nxt;
	logic [CNT_W-1:0] dec_q, dec_nxt;

	// committed frame
	logic             cbank_q, cbank_nxt;
	logic [7:0]       caddr_q, caddr_nxt;
	logic [CNT_W-1:0] clen_q, clen_nxt;
	logic             have_q, have_nxt;

	// pipeline
	logic    s1_valid_q;
	result_t s1_q, res;
	logic    s1_adv, accept;
	logic    out_valid_q;
	result_t out_q;
	logic [7:0] out_data_q;

	// store ports
	logic              ram_we, ram_re;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [7:0]        ram_wdata, ram_rdata;
	logic [2:0]        pos, bit_sel;
	logic [ADDR_W+7:0] waddr_full, raddr_full;

	assign s1_adv = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready = !s1_valid_q || s1_adv;
	assign accept = in_valid && in_ready;

	// configuration writes; the master address belongs to the transmit side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_q <= '0;
			master_mode_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_OWN_ADDRESS: own_q <= cfg_data;
				CFG_DEVICE_IS_MASTER: master_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign pos = rawcnt_q[2:0];
	assign bit_sel = pos - 3'd1;
	assign waddr_full = (ADDR_W+8)'(dec_q) + (cbank_q ? '0 : (ADDR_W+8)'(BANK_DEPTH));
	assign raddr_full = (ADDR_W+8)'(read_index) + (cbank_q ? (ADDR_W+8)'(BANK_DEPTH) : '0);
	assign ram_waddr = waddr_full[ADDR_W-1:0];
	assign ram_raddr = raddr_full[ADDR_W-1:0];
	assign ram_wdata = rx_byte | {high_q[bit_sel], 7'd0};

	// frame parser and result of the accepted transaction
	always_comb begin
		phase_nxt = phase_q;
		faddr_nxt = faddr_q;
		rawlen_nxt = rawlen_q;
		rawcnt_nxt = rawcnt_q;
		sum_nxt = sum_q;
		high_nxt = high_q;
		dec_nxt = dec_q;
		cbank_nxt = cbank_q;
		caddr_nxt = caddr_q;
		clen_nxt = clen_q;
		have_nxt = have_q;
		ram_we = 1'b0;
		ram_re = 1'b0;
		res = '0;
		if (accept && req_type == REQ_RX_BYTE) begin
			if (phase_q != PH_WAIT && rx_byte == START_CODE) begin
				phase_nxt = PH_ADDR;
			end else begin
				case (phase_q)
					PH_ADDR: begin
						faddr_nxt = rx_byte;
						sum_nxt = rx_byte[6:0];
						rawlen_nxt = '0;
						rawcnt_nxt = '0;
						high_nxt = '0;
						dec_nxt = '0;
						phase_nxt = PH_LEN;
					end
					PH_LEN: begin
						rawlen_nxt = rx_byte;
						sum_nxt = sum_q + rx_byte[6:0];
						phase_nxt = (rx_byte == 8'd0) ? PH_CHECK : PH_DATA;
					end
					PH_DATA: begin
						// first byte of a group carries the high bits
						if (pos == 3'd0) begin
							high_nxt = rx_byte[6:0];
						end else if (dec_q < CNT_W'(BANK_DEPTH)) begin
							ram_we = 1'b1;
							dec_nxt = dec_q + CNT_W'(1);
						end
						sum_nxt = sum_q + rx_byte[6:0];
						rawcnt_nxt = rawcnt_q + 8'd1;
						if (rawcnt_nxt == rawlen_q) begin
							phase_nxt = PH_CHECK;
						end
					end
					PH_CHECK: begin
						res.frame_done = 1'b1;
						if ({1'b0, sum_q} == rx_byte) begin
							res.frame_ok = 1'b1;
							cbank_nxt = !cbank_q;
							caddr_nxt = faddr_q;
							clen_nxt = dec_q;
							have_nxt = 1'b1;
							res.ack_request = !master_mode_q && own_q == faddr_q
								&& dec_q != '0;
						end
						phase_nxt = PH_WAIT;
					end
					default: begin
						phase_nxt = (rx_byte == START_CODE) ? PH_ADDR : PH_WAIT;
					end
				endcase
			end
		end else if (accept && req_type == REQ_READ_BYTE) begin
			// committed bytes only, zero at or past the length
			if (have_q && CMP_W'(read_index) < CMP_W'(clen_q)) begin
				ram_re = 1'b1;
				res.rd_hit = 1'b1;
			end
		end
		res.msg_address = caddr_nxt;
		res.msg_length = 8'(clen_nxt);
		res.msg_valid = have_nxt;
	end

	// parser and commit registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT;
			faddr_q <= '0;
			rawlen_q <= '0;
			rawcnt_q <= '0;
			sum_q <= '0;
			high_q <= '0;
			dec_q <= '0;
			cbank_q <= 1'b0;
			caddr_q <= '0;
			clen_q <= '0;
			have_q <= 1'b0;
		end else begin
			phase_q <= phase_nxt;
			faddr_q <= faddr_nxt;
			rawlen_q <= rawlen_nxt;
			rawcnt_q <= rawcnt_nxt;
			sum_q <= sum_nxt;
			high_q <= high_nxt;
			dec_q <= dec_nxt;
			cbank_q <= cbank_nxt;
			caddr_q <= caddr_nxt;
			clen_q <= clen_nxt;
			have_q <= have_nxt;
		end
	end

	// double-buffered message store
	fsr_ram #(
		.WIDTH(8),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// stage 1 waits for the store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_q <= res;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_q <= s1_q;
			out_data_q <= s1_q.rd_hit ? ram_rdata : 8'd0;
		end
	end

	assign out_valid = out_valid_q;
	assign frame_done = out_q.frame_done;
	assign frame_ok = out_q.frame_ok;
	assign ack_request = out_q.ack_request;
	assign read_data = out_data_q;
	assign msg_address = out_q.msg_address;
	assign msg_length = out_q.msg_length;
	assign msg_valid = out_q.msg_valid;

	// a commit always ends a frame, and an ack needs a commit
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_ok |-> frame_done)
		else $error("frame_ok without frame_done");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ack_request |-> frame_ok && msg_valid)
		else $error("ack request without a committed frame");
	// a commit in stage 1 has already updated the committed info
	assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && s1_q.frame_ok |-> have_q)
		else $error("commit not recorded");
	// no store write past the end of a bank
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> dec_q < CNT_W'(BANK_DEPTH))
		else $error("store write past bank end");
	// a read never hits before any frame is committed
	assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && s1_q.rd_hit |-> have_q && s1_q.msg_valid)
		else $error("read hit with no committed frame");

endmodule

`default_nettype wire

>>> tb/tb_framed_serial_receiver.sv
// self-checking testbench for framed_serial_receiver: frames, reads and info requests
// with random sender bursts and receiver stalls, checked against an in-bench frame parser
// depends on fsr_pkg and framed_serial_receiver only
`default_nettype none

module tb_framed_serial_receiver;
	import fsr_pkg::*;

	// spare request code, reported like an info request
	localparam logic [1:0] REQ_SPARE = 2'd3;
	localparam int LONG_HOLD = 400;
	localparam int PHASE_ITEMS = 220;
	localparam int PRINT_CAP = 40;

	typedef struct {
		logic [1:0] req;
		logic [7:0] rx;
		logic [7:0] idx;
	} txn_t;

	typedef struct {
		logic       done;
		logic       ok;
		logic       ack;
		logic [7:0] data;
		logic [7:0] addr;
		logic [7:0] len;
		logic       valid;
	} reply_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] req_type = REQ_INFO;
	logic [7:0] rx_byte = 8'h00;
	logic [7:0] read_index = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       frame_done;
	logic       frame_ok;
	logic       ack_request;
	logic [7:0] read_data;
	logic [7:0] msg_address;
	logic [7:0] msg_length;
	logic       msg_valid;
	logic       cfg_we = 1'b0;
	logic [1:0] cfg_index = CFG_OWN_ADDRESS;
	logic [7:0] cfg_data = 8'h00;

	framed_serial_receiver dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .rx_byte(rx_byte), .read_index(read_index),
		.out_valid(out_valid), .out_ready(out_ready),
		.frame_done(frame_done), .frame_ok(frame_ok), .ack_request(ack_request),
		.read_data(read_data), .msg_address(msg_address), .msg_length(msg_length),
		.msg_valid(msg_valid),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	txn_t   pending_items[$];
	reply_t awaited_replies[$];
	int     pushed_total = 0;
	int     mismatches = 0;
	logic   in_taken = 1'b0;
	int     hold_off_req = 0;

	// parser copy: configuration, frame in progress and committed message
	logic [7:0] own_addr = 8'h00;
	logic [7:0] mstr_cfg = 8'h00;
	logic       dev_master = 1'b0;
	phase_t     phase = PH_WAIT;
	logic [7:0] f_addr = 8'h00;
	logic [7:0] raw_len = 8'h00;
	logic [7:0] raw_cnt = 8'h00;
	logic [6:0] sum7 = 7'h00;
	logic [6:0] grp_hi = 7'h00;
	int         dec_cnt = 0;
	logic [7:0] msg_store [2*BANK_DEPTH];
	logic       bank = 1'b0;
	logic [7:0] c_addr = 8'h00;
	int         c_len = 0;
	logic       have_msg = 1'b0;

	// one transaction through the parser, giving the reply it should produce
	function automatic reply_t parse_and_reply(txn_t t);
		reply_t r;
		logic [7:0] b;
		int pos;
		r.done = 1'b0;
		r.ok = 1'b0;
		r.ack = 1'b0;
		r.data = 8'h00;
		b = t.rx;
		if (t.req == REQ_RX_BYTE) begin
			if (phase != PH_WAIT && b == START_CODE) begin
				phase = PH_ADDR;
			end else begin
				case (phase)
					PH_ADDR: begin
						f_addr = b;
						sum7 = b[6:0];
						raw_len = 8'h00;
						raw_cnt = 8'h00;
						grp_hi = 7'h00;
						dec_cnt = 0;
						phase = PH_LEN;
					end
					PH_LEN: begin
						raw_len = b;
						sum7 = sum7 + b[6:0];
						phase = (b == 8'h00) ? PH_CHECK : PH_DATA;
					end
					PH_DATA: begin
						pos = int'(raw_cnt[2:0]);
						if (pos == 0) begin
							grp_hi = b[6:0];
						end else if (dec_cnt < BANK_DEPTH) begin
							msg_store[(bank ? 0 : BANK_DEPTH) + dec_cnt] =
								b | {grp_hi[pos-1], 7'b0};
							dec_cnt++;
						end
						sum7 = sum7 + b[6:0];
						raw_cnt = raw_cnt + 8'd1;
						if (raw_cnt == raw_len)
							phase = PH_CHECK;
					end
					PH_CHECK: begin
						r.done = 1'b1;
						if ({1'b0, sum7} == b) begin
							r.ok = 1'b1;
							bank = ~bank;
							c_addr = f_addr;
							c_len = dec_cnt;
							have_msg = 1'b1;
							r.ack = !dev_master && own_addr == f_addr && dec_cnt != 0;
						end
						phase = PH_WAIT;
					end
					default: begin
						phase = (b == START_CODE) ? PH_ADDR : PH_WAIT;
					end
				endcase
			end
		end else if (t.req == REQ_READ_BYTE) begin
			if (have_msg && int'(t.idx) < c_len && int'(t.idx) < BANK_DEPTH)
				r.data = msg_store[int'(bank) * BANK_DEPTH + int'(t.idx)];
		end
		r.addr = c_addr;
		r.len = c_len[7:0];
		r.valid = have_msg;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
		if (mismatches < PRINT_CAP)
			$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
		mismatches++;
	endtask

	// stimulus building
	task automatic push_item(logic [1:0] req, logic [7:0] rx, logic [7:0] idx);
		txn_t t;
		t.req = req;
		t.rx = rx;
		t.idx = idx;
		pending_items.push_back(t);
		pushed_total++;
	endtask

	task automatic push_byte(logic [7:0] b);
		push_item(REQ_RX_BYTE, b, 8'($urandom));
	endtask

	// well-formed frame unless corrupt is set; cut >= 0 stops after that many payload bytes
	task automatic queue_frame(logic [7:0] addr, int len, bit corrupt, int cut);
		logic [6:0] s;
		logic [7:0] b;
		logic [7:0] chk;
		push_byte(START_CODE);
		push_byte(addr);
		push_byte(8'(len));
		s = addr[6:0] + len[6:0];
		for (int i = 0; i < len; i++) begin
			if (cut >= 0 && i == cut)
				return;
			b = 8'($urandom_range(0, 254));
			push_byte(b);
			s = s + b[6:0];
		end
		chk = {1'b0, s};
		if (corrupt) begin
			if ($urandom_range(0, 1) == 0)
				chk = {1'b0, s ^ 7'($urandom_range(1, 127))};
			else
				chk = (s == 7'h7F) ? 8'h80 : {1'b1, s};
		end
		push_byte(chk);
	endtask

	task automatic add_random_unit();
		int r;
		int len;
		int n;
		logic [7:0] addr;
		r = $urandom_range(0, 99);
		addr = (own_addr != 8'hFF && $urandom_range(0, 1) == 0) ?
			own_addr : 8'($urandom_range(0, 254));
		len = ($urandom_range(0, 29) == 0) ? $urandom_range(25, 254) : $urandom_range(0, 24);
		if (r < 55) begin
			queue_frame(addr, len, $urandom_range(0, 6) == 0, -1);
			n = $urandom_range(0, 3);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 3) == 0)
					push_item(REQ_READ_BYTE, 8'($urandom), 8'($urandom));
				else
					push_item(REQ_READ_BYTE, 8'($urandom),
						8'($urandom_range(0, (len + 1 > 255) ? 255 : len + 1)));
			end
		end else if (r < 65) begin
			// frame broken off part way, left for the next start byte
			len = $urandom_range(1, 24);
			queue_frame(addr, len, 1'b0, $urandom_range(0, len - 1));
		end else if (r < 75) begin
			push_item(REQ_READ_BYTE, 8'($urandom), 8'($urandom_range(0, 40)));
		end else if (r < 85) begin
			push_item(($urandom_range(0, 1) == 0) ? REQ_INFO : REQ_SPARE,
				8'($urandom), 8'($urandom));
		end else begin
			n = $urandom_range(1, 4);
			for (int i = 0; i < n; i++)
				push_byte(8'($urandom));
		end
	endtask

	// configuration writes happen only while the block is idle
	task automatic write_register(logic [1:0] idx, logic [7:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			CFG_OWN_ADDRESS: own_addr = value;
			CFG_MASTER_ADDRESS: mstr_cfg = value;
			CFG_DEVICE_IS_MASTER: dev_master = value[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_for_drain();
		@(posedge clk);
		while (pending_items.size() != 0 || in_valid || awaited_replies.size() != 0)
			@(posedge clk);
	endtask

	// sender: bursts of random length separated by random gaps
	int burst_left = 8;
	int gap_left = 0;

	always @(negedge clk) begin : sender
		txn_t t;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_items.size() != 0) begin
				t = pending_items.pop_front();
				in_valid <= 1'b1;
				req_type <= t.req;
				rx_byte <= t.rx;
				read_index <= t.idx;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: stall pattern changing mode every so often, plus one long hold-off
	int hold_served = 0;
	int hold_left = 0;
	int stall_mode = 0;
	int stall_timer = 0;
	int rx_cycle = 0;

	always @(negedge clk) begin : receiver
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (hold_served != hold_off_req) begin
			hold_served++;
			hold_left = LONG_HOLD;
			out_ready <= 1'b0;
		end else begin
			rx_cycle++;
			if (stall_timer == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_timer = $urandom_range(20, 120);
			end else begin
				stall_timer--;
			end
			case (stall_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 1) == 0);
				2: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= ((rx_cycle % 7) < 4);
			endcase
		end
	end

	// monitor: check each result transaction, then predict the accepted input
	always @(posedge clk) begin : monitor
		reply_t want;
		txn_t t;
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			in_taken <= in_valid && in_ready;
			if (out_valid && out_ready) begin
				if (awaited_replies.size() == 0) begin
					report_mismatch("unexpected result", 8'(out_valid), 8'h00);
				end else begin
					want = awaited_replies.pop_front();
					if (frame_done !== want.done)
						report_mismatch("frame_done", 8'(frame_done), 8'(want.done));
					if (frame_ok !== want.ok)
						report_mismatch("frame_ok", 8'(frame_ok), 8'(want.ok));
					if (ack_request !== want.ack)
						report_mismatch("ack_request", 8'(ack_request), 8'(want.ack));
					if (read_data !== want.data)
						report_mismatch("read_data", read_data, want.data);
					if (msg_address !== want.addr)
						report_mismatch("msg_address", msg_address, want.addr);
					if (msg_length !== want.len)
						report_mismatch("msg_length", msg_length, want.len);
					if (msg_valid !== want.valid)
						report_mismatch("msg_valid", 8'(msg_valid), 8'(want.valid));
				end
			end
			if (in_valid && in_ready) begin
				t.req = req_type;
				t.rx = rx_byte;
				t.idx = read_index;
				awaited_replies.push_back(parse_and_reply(t));
			end
		end
	end

	// run control: reset, then phases of configuration and stimulus
	initial begin : control
		int start_count;
		logic [7:0] own_v;
		logic [7:0] master_v;
		logic ism_v;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		for (int p = 0; p < 6; p++) begin
			wait_for_drain();
			repeat (4) @(negedge clk);
			case (p)
				0: begin own_v = 8'h00; master_v = 8'hFF; ism_v = 1'b0; end
				1: begin own_v = 8'hFE; master_v = 8'h00; ism_v = 1'b0; end
				2: begin own_v = 8'h5A; master_v = 8'h33; ism_v = 1'b1; end
				3: begin own_v = 8'hFF; master_v = 8'h80; ism_v = 1'b0; end
				default: begin
					own_v = 8'($urandom);
					master_v = 8'($urandom);
					ism_v = 1'($urandom);
				end
			endcase
			write_register(CFG_OWN_ADDRESS, own_v);
			write_register(CFG_MASTER_ADDRESS, master_v);
			write_register(CFG_DEVICE_IS_MASTER, {7'b0, ism_v});
			// long receiver hold-off while the sender keeps offering
			if (p == 1)
				hold_off_req++;
			@(posedge clk);
			if (p == 0) begin
				// nothing committed yet, spare request code
				push_item(REQ_INFO, 8'h00, 8'h00);
				push_item(REQ_READ_BYTE, 8'hFF, 8'h00);
				push_item(REQ_SPARE, 8'hFF, 8'hFF);
				// empty payload to own address: committed but no ack
				push_byte(START_CODE); push_byte(8'h00); push_byte(8'h00); push_byte(8'h00);
				// three raw bytes: all high bits set, low parts at both extremes
				push_byte(START_CODE); push_byte(8'h00); push_byte(8'h03);
				push_byte(8'h7F); push_byte(8'h00); push_byte(8'hFE); push_byte(8'h00);
				// reads inside the length and far past it
				push_item(REQ_READ_BYTE, 8'h00, 8'h00);
				push_item(REQ_READ_BYTE, 8'h00, 8'h01);
				push_item(REQ_READ_BYTE, 8'h00, 8'hFF);
				// checksum wrong only in bit 7
				push_byte(START_CODE); push_byte(8'h01); push_byte(8'h01);
				push_byte(8'h55); push_byte(8'hD7);
				// start byte in the length slot resynchronises
				push_byte(START_CODE); push_byte(8'h02); push_byte(START_CODE);
				push_byte(8'h03); push_byte(8'h00); push_byte(8'h03);
			end
			start_count = pushed_total;
			while (pushed_total - start_count < PHASE_ITEMS)
				add_random_unit();
		end
		wait_for_drain();
		repeat (8) @(posedge clk);
		if (awaited_replies.size() != 0)
			report_mismatch("results missing", 8'(awaited_replies.size()), 8'h00);
		if (mismatches == 0)
			$display("tb_framed_serial_receiver: clean");
		else
			$display("tb_framed_serial_receiver: errors");
		$finish;
	end

	// watchdog
	initial begin : watchdog
		#4000000;
		$display("tb_framed_serial_receiver: errors");
		$finish;
	end

endmodule

`default_nettype wire
